// ===== hw/rtl/first_match_packet_rule_table_unit_defines.svh =====
// assertion macros for the first-match packet rule table
// no dependencies; included by the top-level module, the only one that carries assertions
`ifndef FIRST_MATCH_PACKET_RULE_TABLE_UNIT_DEFINES_SVH
`define FIRST_MATCH_PACKET_RULE_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTH
`define FMPRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fmprt assertion failed");
`define FMPRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fmprt assertion failed");
`else
`define FMPRT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FMPRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/fmprt_pkg.sv =====
// shared types, codes and the rule compare function of the packet rule table
// no dependencies
package fmprt_pkg;

  localparam logic [1:0] OP_CLASSIFY = 2'd0;
  localparam logic [1:0] OP_APPEND   = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;

  localparam logic [2:0] HOOK_LOCAL_IN  = 3'd1;
  localparam logic [2:0] HOOK_LOCAL_OUT = 3'd3;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // care mask bit positions
  localparam int CARE_SRC_IP   = 0;
  localparam int CARE_SRC_PORT = 1;
  localparam int CARE_DST_IP   = 2;
  localparam int CARE_DST_PORT = 3;
  localparam int CARE_PROTO    = 4;
  localparam int CARE_MINUTE   = 5;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [5:0]  minute;
  } key_t;

  typedef struct packed {
    key_t       key;
    logic [5:0] care;
    logic       action;
  } rule_t;

  // result token that walks the cell chain
  typedef struct packed {
    logic valid;
    logic found;
    logic action;
  } tok_t;

  function automatic logic rule_hits(rule_t r, key_t k);
    logic ported;
    logic known;
    logic hit;
    ported = (k.protocol == PROTO_TCP) || (k.protocol == PROTO_UDP);
    known  = ported || (k.protocol == PROTO_ICMP);
    hit    = (r.care != 6'd0);
    if (r.care[CARE_SRC_IP] && (r.key.src_ip != k.src_ip)) hit = 1'b0;
    if (r.care[CARE_DST_IP] && (r.key.dst_ip != k.dst_ip)) hit = 1'b0;
    if (r.care[CARE_SRC_PORT] && (!ported || (r.key.src_port != k.src_port))) hit = 1'b0;
    if (r.care[CARE_DST_PORT] && (!ported || (r.key.dst_port != k.dst_port))) hit = 1'b0;
    if (r.care[CARE_PROTO] && (!known || (r.key.protocol != k.protocol))) hit = 1'b0;
    if (r.care[CARE_MINUTE] && (r.key.minute != k.minute)) hit = 1'b0;
    return hit;
  endfunction

endpackage

// ===== hw/rtl/fmprt_cell.sv =====
// one rule slot of the chain: holds a rule and updates the passing result token
// depends on fmprt_pkg
module fmprt_cell #(
  parameter int IDX_W    = 8,
  parameter int CNT_W    = 9,
  parameter int CELL_IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  fmprt_pkg::rule_t    wr_rule,
  input  logic [CNT_W-1:0]    count,
  input  fmprt_pkg::key_t     key,
  input  fmprt_pkg::tok_t     tok_in,
  input  logic [IDX_W-1:0]    idx_in,
  output fmprt_pkg::tok_t     tok_out,
  output logic [IDX_W-1:0]    idx_out
);
  import fmprt_pkg::*;

  rule_t            rule_r;
  tok_t             tok_r;
  tok_t             tok_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic             active;
  logic             hit;

  assign active = CNT_W'(CELL_IDX) < count;
  assign hit    = active && rule_hits(rule_r, key);

  always_comb begin
    tok_nxt       = tok_in;
    idx_nxt       = idx_in;
    tok_nxt.found = tok_in.found | hit;
    // first hit in chain order wins
    if (!tok_in.found && hit) begin
      tok_nxt.action = rule_r.action;
      idx_nxt        = IDX_W'(CELL_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (count == CNT_W'(CELL_IDX))) begin
      rule_r <= wr_rule;
    end
    idx_r <= idx_nxt;
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;
  assign idx_out = idx_r;

endmodule

// ===== hw/rtl/first_match_packet_rule_table_unit.sv =====
// first-match packet rule table, top level
// depends on fmprt_pkg, fmprt_cell and first_match_packet_rule_table_unit_defines.svh
//
// Rules live in a chain of RULE_SLOTS cells, one rule per cell, in append order.
// Append, clear, the unused operation code and a classify on any hook other than 1 or 3
// take effect at the accepting edge, and their result goes to the output register once
// that register is free. A classify request on hook 1 or 3 sends a result token down
// the chain, one cell per cycle, while the packet key stays broadcast to every cell;
// the first cell below the rule count whose rule matches marks the token with its
// index and action, and the result is taken from the token as it leaves the last cell.
// The block takes one request at a time and accepts no new request until the last
// one's result has moved to the output register. A finished result sits in an output
// register, so the next request is accepted while it waits to be taken.
`include "first_match_packet_rule_table_unit_defines.svh"

module first_match_packet_rule_table_unit #(
  parameter int RULE_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [2:0]  in_hook,
  input  logic [31:0] in_src_ip,
  input  logic [31:0] in_dst_ip,
  input  logic [7:0]  in_protocol,
  input  logic [15:0] in_src_port,
  input  logic [15:0] in_dst_port,
  input  logic [5:0]  in_minute,
  input  logic [5:0]  in_care_mask,
  input  logic        in_rule_action,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_verdict,
  output logic        out_matched,
  output logic [7:0]  out_rule_index,
  output logic        out_table_full
);
  import fmprt_pkg::*;

  localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int CNT_W = $clog2(RULE_SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic             launch_r, launch_nxt;
  key_t             key_r, key_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // pending result, waiting for the output register
  logic       res_verdict_r, res_verdict_nxt;
  logic       res_matched_r, res_matched_nxt;
  logic [7:0] res_idx_r, res_idx_nxt;
  logic       res_full_r, res_full_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic       out_verdict_r, out_verdict_nxt;
  logic       out_matched_r, out_matched_nxt;
  logic [7:0] out_idx_r, out_idx_nxt;
  logic       out_full_r, out_full_nxt;

  logic             in_accept;
  logic             room;
  logic             wr_en;
  rule_t            wr_rule;
  key_t             in_key;
  tok_t             tok   [0:RULE_SLOTS];
  logic [IDX_W-1:0] idx   [0:RULE_SLOTS];
  logic [IDX_W+7:0] tail_idx_ext;
  logic [CNT_W+7:0] count_ext;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign room      = count_r < CNT_W'(RULE_SLOTS);

  assign in_key.src_ip   = in_src_ip;
  assign in_key.dst_ip   = in_dst_ip;
  assign in_key.protocol = in_protocol;
  assign in_key.src_port = in_src_port;
  assign in_key.dst_port = in_dst_port;
  assign in_key.minute   = in_minute;

  assign wr_rule.key    = in_key;
  assign wr_rule.care   = in_care_mask;
  assign wr_rule.action = in_rule_action;

  // the append lands in the cell whose index equals the current rule count
  assign wr_en = in_accept && (in_operation == OP_APPEND) && room;

  // token enters the head of the chain in the cycle after the classify is accepted
  assign tok[0].valid  = launch_r;
  assign tok[0].found  = 1'b0;
  assign tok[0].action = 1'b0;
  assign idx[0]        = '0;

  for (genvar g = 0; g < RULE_SLOTS; g++) begin : g_cell
    fmprt_cell #(
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (wr_en),
      .wr_rule (wr_rule),
      .count   (count_r),
      .key     (key_r),
      .tok_in  (tok[g]),
      .idx_in  (idx[g]),
      .tok_out (tok[g+1]),
      .idx_out (idx[g+1])
    );
  end

  // rule_index is the slot number taken modulo 256
  assign tail_idx_ext = {8'd0, idx[RULE_SLOTS]};
  assign count_ext    = {8'd0, count_r};

  always_comb begin
    state_nxt       = state_r;
    launch_nxt      = 1'b0;
    key_nxt         = key_r;
    count_nxt       = count_r;
    res_verdict_nxt = res_verdict_r;
    res_matched_nxt = res_matched_r;
    res_idx_nxt     = res_idx_r;
    res_full_nxt    = res_full_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_verdict_nxt = out_verdict_r;
    out_matched_nxt = out_matched_r;
    out_idx_nxt     = out_idx_r;
    out_full_nxt    = out_full_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          key_nxt         = in_key;
          res_verdict_nxt = 1'b0;
          res_matched_nxt = 1'b0;
          res_idx_nxt     = 8'd0;
          res_full_nxt    = 1'b0;
          state_nxt       = ST_DONE;
          unique case (in_operation)
            OP_CLASSIFY: begin
              // other hooks pass everything without a lookup
              if ((in_hook == HOOK_LOCAL_IN) || (in_hook == HOOK_LOCAL_OUT)) begin
                state_nxt  = ST_SCAN;
                launch_nxt = 1'b1;
              end
            end
            OP_APPEND: begin
              if (room) begin
                res_idx_nxt = count_ext[7:0];
                count_nxt   = count_r + CNT_W'(1);
              end else begin
                res_full_nxt = 1'b1;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // token has left the last cell
        if (tok[RULE_SLOTS].valid) begin
          res_matched_nxt = tok[RULE_SLOTS].found;
          res_verdict_nxt = tok[RULE_SLOTS].found && tok[RULE_SLOTS].action;
          res_idx_nxt     = tok[RULE_SLOTS].found ? tail_idx_ext[7:0] : 8'd0;
          state_nxt       = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_verdict_nxt = res_verdict_r;
          out_matched_nxt = res_matched_r;
          out_idx_nxt     = res_idx_r;
          out_full_nxt    = res_full_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r         <= key_nxt;
    res_verdict_r <= res_verdict_nxt;
    res_matched_r <= res_matched_nxt;
    res_idx_r     <= res_idx_nxt;
    res_full_r    <= res_full_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_matched_r <= out_matched_nxt;
    out_idx_r     <= out_idx_nxt;
    out_full_r    <= out_full_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launch_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_verdict    = out_verdict_r;
  assign out_matched    = out_matched_r;
  assign out_rule_index = out_idx_r;
  assign out_table_full = out_full_r;

  `FMPRT_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(RULE_SLOTS))
  `FMPRT_ASSERT_NOW(a_tail_in_scan, clk, rst_n, tok[RULE_SLOTS].valid, state_r == ST_SCAN)
  `FMPRT_ASSERT_NEXT(a_append_grows, clk, rst_n, wr_en,
                     count_r == $past(count_r) + CNT_W'(1))
  `FMPRT_ASSERT_NOW(a_drop_needs_match, clk, rst_n, out_valid_r,
                    out_matched_r || !out_verdict_r)
  `FMPRT_ASSERT_NOW(a_full_no_match, clk, rst_n, out_valid_r,
                    !(out_full_r && out_matched_r))

endmodule

// ===== tb/sv/tb_first_match_packet_rule_table_unit.sv =====
// self-checking testbench for the first-match packet rule table
// depends on fmprt_pkg and first_match_packet_rule_table_unit; an in-bench copy of the
// rule table predicts every result, which is checked in order against the result channel
`timescale 1ns / 100ps

module tb_first_match_packet_rule_table_unit;
  import fmprt_pkg::*;

  localparam int RULE_SLOTS = 256;
  // generous ceiling: a full-table classify walk, both stall bursts, ~1200 requests, x5
  localparam int CYCLE_LIMIT = 2_000_000;
  // operation code with no meaning in the block
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic       verdict;
    logic       matched;
    logic [7:0] rule_index;
    logic       table_full;
  } outcome_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_operation;
  logic [2:0]  in_hook;
  logic [31:0] in_src_ip;
  logic [31:0] in_dst_ip;
  logic [7:0]  in_protocol;
  logic [15:0] in_src_port;
  logic [15:0] in_dst_port;
  logic [5:0]  in_minute;
  logic [5:0]  in_care_mask;
  logic        in_rule_action;
  logic        out_valid;
  logic        out_stall;
  logic        out_verdict;
  logic        out_matched;
  logic [7:0]  out_rule_index;
  logic        out_table_full;

  // in-bench copy of the rule table
  rule_t       rule_book [RULE_SLOTS];
  int unsigned rule_total;

  // verdicts still owed by the block, oldest first
  outcome_t    expected_outcomes [$];

  // when low, neither side inserts idle or stall bursts
  bit          idling_on;
  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned rule_hits_seen;
  int unsigned full_refusals_seen;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  first_match_packet_rule_table_unit #(.RULE_SLOTS(RULE_SLOTS)) dut (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------

  function automatic logic [5:0] care_bit(input int pos);
    return 6'(1) << pos;
  endfunction

  // a rule hits when it cares about something and every cared field agrees
  function automatic logic packet_hits_rule(input rule_t r, input key_t pkt);
    logic       l4;
    logic       recognized;
    logic [5:0] agree;
    l4         = (pkt.protocol == PROTO_TCP) || (pkt.protocol == PROTO_UDP);
    recognized = l4 || (pkt.protocol == PROTO_ICMP);
    agree[CARE_SRC_IP]   = (r.key.src_ip == pkt.src_ip);
    agree[CARE_DST_IP]   = (r.key.dst_ip == pkt.dst_ip);
    // ports only mean something for tcp and udp
    agree[CARE_SRC_PORT] = l4 && (r.key.src_port == pkt.src_port);
    agree[CARE_DST_PORT] = l4 && (r.key.dst_port == pkt.dst_port);
    // protocol compare only for icmp, tcp and udp packets
    agree[CARE_PROTO]    = recognized && (r.key.protocol == pkt.protocol);
    agree[CARE_MINUTE]   = (r.key.minute == pkt.minute);
    return (r.care != 6'd0) && ((agree & r.care) == r.care);
  endfunction

  // apply one request to the table copy and return what the block must answer
  function automatic outcome_t apply_request(input logic [1:0] op, input logic [2:0] hook,
                                             input key_t pkt, input logic [5:0] care,
                                             input logic act);
    outcome_t res;
    logic     found;
    res   = '0;
    found = 1'b0;
    case (op)
      OP_CLASSIFY: begin
        // other hooks pass everything untouched
        if (hook == HOOK_LOCAL_IN || hook == HOOK_LOCAL_OUT) begin
          for (int i = 0; i < int'(rule_total); i++) begin
            if (!found && packet_hits_rule(rule_book[i], pkt)) begin
              found          = 1'b1;
              res.verdict    = rule_book[i].action;
              res.matched    = 1'b1;
              res.rule_index = 8'(i);
            end
          end
        end
      end
      OP_APPEND: begin
        if (rule_total >= RULE_SLOTS) begin
          res.table_full = 1'b1;
        end else begin
          rule_book[rule_total] = '{key: pkt, care: care, action: act};
          res.rule_index        = 8'(rule_total);
          rule_total++;
        end
      end
      OP_CLEAR: begin
        rule_total = 0;
      end
      default: begin
        // unused code leaves the table alone
      end
    endcase
    return res;
  endfunction

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------

  function automatic key_t make_key(input logic [31:0] sip, input logic [31:0] dip,
                                    input logic [7:0] proto, input logic [15:0] sp,
                                    input logic [15:0] dp, input logic [5:0] mn);
    return '{src_ip: sip, dst_ip: dip, protocol: proto, src_port: sp, dst_port: dp,
             minute: mn};
  endfunction

  // mostly the three recognized protocols, sometimes any byte
  function automatic logic [7:0] random_protocol();
    case ($urandom_range(0, 3))
      0:       return PROTO_ICMP;
      1:       return PROTO_TCP;
      2:       return PROTO_UDP;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic key_t random_key();
    logic [5:0] mn;
    // minutes past 59 are still legal bit patterns
    mn = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 59));
    return make_key($urandom, $urandom, random_protocol(), 16'($urandom), 16'($urandom), mn);
  endfunction

  function automatic logic [2:0] random_hook();
    case ($urandom_range(0, 9)) inside
      [0:3]:   return HOOK_LOCAL_IN;
      [4:6]:   return HOOK_LOCAL_OUT;
      default: return 3'($urandom_range(0, 7));
    endcase
  endfunction

  // packets mostly copy a stored rule so lookups actually hit, some with one field bent
  function automatic key_t probe_key();
    key_t k;
    if (rule_total == 0 || $urandom_range(0, 4) == 0) return random_key();
    k = rule_book[$urandom_range(0, rule_total - 1)].key;
    case ($urandom_range(0, 9))
      0:       k.src_ip ^= 32'(1) << $urandom_range(0, 31);
      1:       k.dst_ip = $urandom;
      2:       k.src_port = 16'($urandom);
      3:       k.dst_port = 16'($urandom);
      4:       k.protocol = random_protocol();
      5:       k.minute = 6'($urandom_range(0, 63));
      default: ;
    endcase
    return k;
  endfunction

  // drive one request, hold it until accepted, then log the expected verdict
  task automatic send_request(input logic [1:0] op, input logic [2:0] hook, input key_t pkt,
                              input logic [5:0] care, input logic act);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_hook        <= hook;
    in_src_ip      <= pkt.src_ip;
    in_dst_ip      <= pkt.dst_ip;
    in_protocol    <= pkt.protocol;
    in_src_port    <= pkt.src_port;
    in_dst_port    <= pkt.dst_port;
    in_minute      <= pkt.minute;
    in_care_mask   <= care;
    in_rule_action <= act;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_outcomes.push_back(apply_request(op, hook, pkt, care, act));
    requests_sent++;
  endtask

  // hold off the sender until every owed result has been taken
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_outcomes.size() != 0);
  endtask

  task automatic send_random_request();
    int unsigned pick;
    logic [5:0]  care;
    pick = $urandom_range(0, 99);
    // a few rules care about nothing and must never fire
    care = ($urandom_range(0, 9) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
    if (pick < 55)
      send_request(OP_CLASSIFY, random_hook(), probe_key(), care, 1'($urandom));
    else if (pick < 91)
      send_request(OP_APPEND, 3'($urandom), random_key(), care, 1'($urandom));
    else if (pick < 96)
      send_request(OP_CLEAR, 3'($urandom), random_key(), care, 1'($urandom));
    else
      send_request(OP_UNUSED, 3'($urandom), random_key(), care, 1'($urandom));
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // field extremes, every operation and each corner of the match rules
  task automatic test_directed_cases();
    key_t all_ones;
    key_t k;
    all_ones = make_key('1, '1, PROTO_TCP, '1, '1, 6'd59);
    // empty table accepts
    send_request(OP_CLASSIFY, HOOK_LOCAL_IN, all_ones, 6'h3f, 1'b1);
    // rule 0 cares about nothing, so it never hits
    send_request(OP_APPEND, 3'd0, all_ones, 6'd0, 1'b1);
    send_request(OP_CLASSIFY, HOOK_LOCAL_OUT, all_ones, 6'd0, 1'b0);
    // rule 1 cares about every field: all-ones addresses and ports, tcp, minute 59
    send_request(OP_APPEND, 3'd7, all_ones, 6'h3f, 1'b1);
    send_request(OP_CLASSIFY, HOOK_LOCAL_IN, all_ones, 6'h3f, 1'b0);
    send_request(OP_CLASSIFY, HOOK_LOCAL_OUT, all_ones, 6'd0, 1'b1);
    // unchecked hooks let the same packet through
    send_request(OP_CLASSIFY, 3'd0, all_ones, 6'd0, 1'b0);
    send_request(OP_CLASSIFY, 3'd2, all_ones, 6'd0, 1'b0);
    send_request(OP_CLASSIFY, 3'd4, all_ones, 6'd0, 1'b0);
    send_request(OP_CLASSIFY, 3'd7, all_ones, 6'd0, 1'b0);
    // port rule: hits only for tcp or udp packets
    k = make_key('0, '0, PROTO_UDP, '0, '0, 6'd0);
    send_request(OP_APPEND, HOOK_LOCAL_IN, k, care_bit(CARE_SRC_PORT), 1'b0);
    k.protocol = PROTO_ICMP;
    send_request(OP_CLASSIFY, HOOK_LOCAL_IN, k, 6'd0, 1'b0);
    k.protocol = PROTO_UDP;
    send_request(OP_CLASSIFY, HOOK_LOCAL_OUT, k, 6'd0, 1'b0);
    // protocol rule on an unknown protocol never hits, even on an equal packet
    k = make_key(32'h0a00_0001, 32'h0a00_0002, 8'd50, 16'd80, 16'd443, 6'd30);
    send_request(OP_APPEND, HOOK_LOCAL_IN, k, care_bit(CARE_PROTO), 1'b1);
    send_request(OP_CLASSIFY, HOOK_LOCAL_IN, k, 6'd0, 1'b0);
    k.protocol = PROTO_ICMP;
    send_request(OP_APPEND, HOOK_LOCAL_IN, k, care_bit(CARE_PROTO), 1'b1);
    send_request(OP_CLASSIFY, HOOK_LOCAL_IN, k, 6'd0, 1'b0);
    // minute compared as raw bits, 63 included
    k = make_key('0, '0, 8'd0, '0, '0, 6'd63);
    send_request(OP_APPEND, HOOK_LOCAL_OUT, k, care_bit(CARE_MINUTE), 1'b1);
    send_request(OP_CLASSIFY, HOOK_LOCAL_OUT, k, 6'd0, 1'b0);
    k.minute = 6'd0;
    send_request(OP_CLASSIFY, HOOK_LOCAL_OUT, k, 6'd0, 1'b0);
    // unused code changes nothing; clear empties the table
    send_request(OP_UNUSED, HOOK_LOCAL_IN, all_ones, 6'h3f, 1'b1);
    send_request(OP_CLEAR, HOOK_LOCAL_IN, all_ones, 6'h3f, 1'b1);
    send_request(OP_CLASSIFY, HOOK_LOCAL_IN, all_ones, 6'd0, 1'b0);
    // appends restart at index 0 after a clear
    send_request(OP_APPEND, 3'd0, make_key('0, '0, 8'd0, '0, '0, 6'd0),
                 care_bit(CARE_DST_IP), 1'b0);
    send_request(OP_CLASSIFY, HOOK_LOCAL_OUT, make_key('1, '0, 8'd0, '0, '0, 6'd0), 6'd0, 1'b0);
  endtask

  // fill every slot, overflow twice, look up the last, first and middle rule, then clear and look again
  task automatic test_table_capacity();
    key_t k;
    wait_for_results();
    send_request(OP_CLEAR, HOOK_LOCAL_IN, random_key(), 6'd0, 1'b0);
    for (int i = 0; i < RULE_SLOTS; i++) begin
      k        = random_key();
      k.src_ip = {24'hc0a800, 8'(i)};
      send_request(OP_APPEND, 3'($urandom), k, care_bit(CARE_SRC_IP), 1'(i));
    end
    // full table refuses the rule and stores nothing
    send_request(OP_APPEND, HOOK_LOCAL_IN, random_key(), 6'h3f, 1'b1);
    send_request(OP_APPEND, HOOK_LOCAL_OUT, random_key(), 6'h01, 1'b0);
    k = random_key();
    k.src_ip = 32'hc0a8_00ff;
    send_request(OP_CLASSIFY, HOOK_LOCAL_OUT, k, 6'd0, 1'b0);
    k.src_ip = 32'hc0a8_0000;
    send_request(OP_CLASSIFY, HOOK_LOCAL_IN, k, 6'd0, 1'b0);
    k.src_ip = 32'hc0a8_0080;
    send_request(OP_CLASSIFY, HOOK_LOCAL_IN, k, 6'd0, 1'b0);
    send_request(OP_CLEAR, 3'd0, random_key(), 6'd0, 1'b0);
    send_request(OP_CLASSIFY, HOOK_LOCAL_OUT, k, 6'd0, 1'b0);
  endtask

  // bulk random traffic with idling on both sides and one full drain midway
  task automatic test_random_traffic(input int count);
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) wait_for_results();
      send_random_request();
    end
  endtask

  // back-to-back traffic with no idling at all
  task automatic test_steady_tail(input int count);
    idling_on = 1'b0;
    for (int n = 0; n < count; n++) send_random_request();
  endtask

  // ------------------------------------------------------------------
  // result side
  // ------------------------------------------------------------------

  // random stall bursts while idling is on, long open stretches in between
  initial begin : result_backpressure
    int unsigned span;
    forever begin
      if (idling_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        span = $urandom_range(1, 17);
      end else begin
        out_stall <= 1'b0;
        span = $urandom_range(1, 40);
      end
      repeat (span) @(posedge clk);
    end
  end

  // compare each taken result with the oldest expectation
  always @(posedge clk) begin : result_check
    outcome_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with nothing expected: verdict %0b matched %0b index %0d full %0b",
                   $realtime, out_verdict, out_matched, out_rule_index, out_table_full);
      end else begin
        want = expected_outcomes.pop_front();
        results_checked++;
        if (want.matched) rule_hits_seen++;
        if (want.table_full) full_refusals_seen++;
        if (out_verdict !== want.verdict || out_matched !== want.matched ||
            out_rule_index !== want.rule_index || out_table_full !== want.table_full) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"%0t: result %0d mismatch: expected verdict %0b matched %0b index %0d",
                      " full %0b, got verdict %0b matched %0b index %0d full %0b"},
                     $realtime, results_checked, want.verdict, want.matched, want.rule_index,
                     want.table_full, out_verdict, out_matched, out_rule_index,
                     out_table_full);
        end
      end
    end
  end

  // runaway guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results owed", cycle_count,
               expected_outcomes.size());
      $display("tb_first_match_packet_rule_table_unit: FAIL");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------

  initial begin
    idling_on      = 1'b1;
    rule_total     = 0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_operation   <= OP_CLASSIFY;
    in_hook        <= '0;
    in_src_ip      <= '0;
    in_dst_ip      <= '0;
    in_protocol    <= '0;
    in_src_port    <= '0;
    in_dst_port    <= '0;
    in_minute      <= '0;
    in_care_mask   <= '0;
    in_rule_action <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_table_capacity();
    test_random_traffic(740);
    test_steady_tail(120);

    // let the last walk finish and watch for stray results
    wait_for_results();
    repeat (RULE_SLOTS + 16) @(posedge clk);
    if (expected_outcomes.size() != 0) mismatch_count++;

    $display("sent %0d requests and checked %0d results: %0d rule hits, %0d full-table refusals",
             requests_sent, results_checked, rule_hits_seen, full_refusals_seen);
    $display("%0d mismatches over %0d cycles", mismatch_count, cycle_count);
    if (mismatch_count == 0) begin
      $display("tb_first_match_packet_rule_table_unit: PASS");
    end else begin
      $display("tb_first_match_packet_rule_table_unit: FAIL");
    end
    $finish;
  end

endmodule
